// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/pbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbrd_pkg
// Types, constants and helper functions of the packed block pixel decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

    localparam int unsigned NCODE = 14;
    localparam int unsigned CODE_W = 14;
    localparam int unsigned VAL_W = 16;
    localparam int unsigned SH_W = 3;

    localparam logic [VAL_W-1:0] BASE_UNIT = 16'h0200;
    localparam logic [VAL_W-1:0] PIX_BIAS = 16'h000f;
    localparam logic [1:0] EXP_WIDE = 2'd3;
    localparam logic [SH_W-1:0] SH_WIDE = 3'd4;

    typedef struct packed {
        logic [63:0] block_bytes_lo;
        logic [63:0] block_bytes_hi;
    } t_pbrd_in_req;

    typedef struct packed {
        logic [15:0] pixel_0;
        logic [15:0] pixel_1;
        logic [15:0] pixel_2;
        logic [15:0] pixel_3;
        logic [15:0] pixel_4;
        logic [15:0] pixel_5;
        logic [15:0] pixel_6;
        logic [15:0] pixel_7;
        logic [15:0] pixel_8;
        logic [15:0] pixel_9;
        logic [15:0] pixel_10;
    } t_pbrd_out_req;

    // per-parity tracker: act = first value seen nonzero, last = last value
    typedef struct packed {
        logic             act;
        logic [VAL_W-1:0] last;
    } t_pbrd_trk;

    function automatic logic [SH_W-1:0] f_shamt(logic [1:0] e);
        return (e == EXP_WIDE) ? SH_WIDE : {1'b0, e};
    endfunction

    function automatic logic [VAL_W-1:0] f_val(t_pbrd_trk t, logic [CODE_W-1:0] code,
                                              logic [SH_W-1:0] sh);
        logic [VAL_W-1:0] scaled;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] adj;
        scaled = VAL_W'(code) << sh;
        base = BASE_UNIT << sh;
        adj = (sh != SH_WIDE && t.last > base) ? (t.last - base) : '0;
        return t.act ? (scaled + adj) : VAL_W'(code);
    endfunction

    function automatic t_pbrd_trk f_next(t_pbrd_trk t, logic [CODE_W-1:0] code,
                                         logic [VAL_W-1:0] v);
        t_pbrd_trk n;
        n.act = t.act | (code != '0);
        n.last = v;
        return n;
    endfunction

    function automatic logic [15:0] f_pix(logic [VAL_W-1:0] v);
        return (v < PIX_BIAS) ? 16'h0000 : 16'(v - PIX_BIAS);
    endfunction

endpackage

// ===== hw/rtl/packed_block_raw_pixel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// packed_block_raw_pixel_decoder_unit
// Decodes one 16-byte packed raw block into eleven 16-bit pixels.
//
// Input channel: i_in_valid / o_in_stall carry one block request (i_in_req),
// bytes 0..7 in block_bytes_lo and 8..15 in block_bytes_hi, byte 0 lowest.
// Output channel: o_out_valid / i_out_stall carry one pixel request
// (o_out_req) per block, pixel_0 first in block order.
// A request moves when valid is high and stall is low at a rising edge.
// Path: the input register, then the decode logic into the result register,
// which drives o_out_valid and o_out_req.
// Throughput: one block per cycle while i_out_stall is low; the decode is a
// single pass with no state carried between blocks.
// Output stall: the result register holds; the input register still takes
// one more block, and o_in_stall rises only when both registers are full.
// Reset (i_rst_n low, synchronous): both registers empty, no output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packed_block_raw_pixel_decoder_unit
    import pbrd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_pbrd_in_req  i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_pbrd_out_req o_out_req
);

    logic          r_in_valid;
    t_pbrd_in_req  r_in_req;
    logic          r_out_valid;
    t_pbrd_out_req r_out_req;
    logic          n_in_valid;
    logic          n_out_valid;
    logic          w_out_en;
    logic          w_in_en;
    t_pbrd_out_req w_pix;

    assign w_out_en = !r_out_valid || !i_out_stall;
    assign w_in_en  = !r_in_valid || w_out_en;

    assign n_in_valid  = w_in_en ? i_in_valid : r_in_valid;
    assign n_out_valid = w_out_en ? r_in_valid : r_out_valid;

    pbrd_decode u_decode (
        .i_blk (r_in_req),
        .o_pix (w_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_en) begin
            r_in_req <= i_in_req;
        end
        if (w_out_en) begin
            r_out_req <= w_pix;
        end
    end

    assign o_in_stall  = !w_in_en;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    `ASSERT_CLK(a_rst_empty, i_clk, i_rst_n, $past(!i_rst_n) |-> !o_out_valid)
    `ASSERT_NXT(a_in_taken, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_in_valid)
    `ASSERT_NXT(a_in_hold, i_clk, i_rst_n, r_in_valid && r_out_valid && i_out_stall,
                r_in_valid && $stable(r_in_req))
    `ASSERT_NXT(a_out_load, i_clk, i_rst_n, r_in_valid && w_out_en,
                o_out_valid && (o_out_req == $past(w_pix)))

endmodule

// ===== hw/rtl/pbrd_decode.sv =====
// ----------------------------------------------------------------------------
// pbrd_decode
// Combinational unpack of one 16-byte block into eleven pixels.
// ----------------------------------------------------------------------------
module pbrd_decode
    import pbrd_pkg::*;
(
    input  t_pbrd_in_req  i_blk,
    output t_pbrd_out_req o_pix
);

    logic [127:0]       w_bits;
    logic [CODE_W-1:0]  w_code [NCODE];
    logic [SH_W-1:0]    w_sh0;
    logic [SH_W-1:0]    w_sh1;
    logic [SH_W-1:0]    w_sh2;
    logic [VAL_W-1:0]   w_v [11];
    t_pbrd_trk          w_te [6];
    t_pbrd_trk          w_to [5];

    // byte 15 first, big-endian bit stream
    assign w_bits = {i_blk.block_bytes_hi, i_blk.block_bytes_lo};

    assign w_code[0]  = w_bits[127:114];
    assign w_code[1]  = w_bits[113:100];
    assign w_code[2]  = CODE_W'(w_bits[99:98]);
    assign w_code[3]  = CODE_W'(w_bits[97:88]);
    assign w_code[4]  = CODE_W'(w_bits[87:78]);
    assign w_code[5]  = CODE_W'(w_bits[77:68]);
    assign w_code[6]  = CODE_W'(w_bits[67:66]);
    assign w_code[7]  = CODE_W'(w_bits[65:56]);
    assign w_code[8]  = CODE_W'(w_bits[55:46]);
    assign w_code[9]  = CODE_W'(w_bits[45:36]);
    assign w_code[10] = CODE_W'(w_bits[35:34]);
    assign w_code[11] = CODE_W'(w_bits[33:24]);
    assign w_code[12] = CODE_W'(w_bits[23:14]);
    assign w_code[13] = CODE_W'(w_bits[13:4]);

    assign w_sh0 = f_shamt(w_code[2][1:0]);
    assign w_sh1 = f_shamt(w_code[6][1:0]);
    assign w_sh2 = f_shamt(w_code[10][1:0]);

    always_comb begin
        w_te[0] = '0;
        w_to[0] = '0;
        // pixel 0 / 1: 14-bit codes
        w_v[0]  = f_val(w_te[0], w_code[0], '0);
        w_te[1] = f_next(w_te[0], w_code[0], w_v[0]);
        w_v[1]  = f_val(w_to[0], w_code[1], '0);
        w_to[1] = f_next(w_to[0], w_code[1], w_v[1]);
        // group 0
        w_v[2]  = f_val(w_te[1], w_code[3], w_sh0);
        w_te[2] = f_next(w_te[1], w_code[3], w_v[2]);
        w_v[3]  = f_val(w_to[1], w_code[4], w_sh0);
        w_to[2] = f_next(w_to[1], w_code[4], w_v[3]);
        w_v[4]  = f_val(w_te[2], w_code[5], w_sh0);
        w_te[3] = f_next(w_te[2], w_code[5], w_v[4]);
        // group 1
        w_v[5]  = f_val(w_to[2], w_code[7], w_sh1);
        w_to[3] = f_next(w_to[2], w_code[7], w_v[5]);
        w_v[6]  = f_val(w_te[3], w_code[8], w_sh1);
        w_te[4] = f_next(w_te[3], w_code[8], w_v[6]);
        w_v[7]  = f_val(w_to[3], w_code[9], w_sh1);
        w_to[4] = f_next(w_to[3], w_code[9], w_v[7]);
        // group 2
        w_v[8]  = f_val(w_te[4], w_code[11], w_sh2);
        w_te[5] = f_next(w_te[4], w_code[11], w_v[8]);
        w_v[9]  = f_val(w_to[4], w_code[12], w_sh2);
        w_v[10] = f_val(w_te[5], w_code[13], w_sh2);
    end

    assign o_pix.pixel_0  = f_pix(w_v[0]);
    assign o_pix.pixel_1  = f_pix(w_v[1]);
    assign o_pix.pixel_2  = f_pix(w_v[2]);
    assign o_pix.pixel_3  = f_pix(w_v[3]);
    assign o_pix.pixel_4  = f_pix(w_v[4]);
    assign o_pix.pixel_5  = f_pix(w_v[5]);
    assign o_pix.pixel_6  = f_pix(w_v[6]);
    assign o_pix.pixel_7  = f_pix(w_v[7]);
    assign o_pix.pixel_8  = f_pix(w_v[8]);
    assign o_pix.pixel_9  = f_pix(w_v[9]);
    assign o_pix.pixel_10 = f_pix(w_v[10]);

endmodule
